/* rtl/prq_pkg.sv */
// Package for the packet ring queue: sizes, action and status codes, and the
// structs passed between the controller and the top level. No dependencies.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int QUEUE_DEPTH  = 8;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_PAYLOAD  = 128;
    localparam int SLOT_STRIDE  = HEADER_BYTES + MAX_PAYLOAD;
    localparam int SLOT_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int POS_W        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_DEPTH    = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int ADDR_W       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam logic [2:0] ACT_BEGIN_ADD     = 3'd0;
    localparam logic [2:0] ACT_PAYLOAD_BYTE  = 3'd1;
    localparam logic [2:0] ACT_REMOVE_OLDEST = 3'd2;
    localparam logic [2:0] ACT_REMOVE_NEWEST = 3'd3;
    localparam logic [2:0] ACT_READ_OLDEST   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_ADD_OPEN = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;
    localparam logic [2:0] ST_NO_ADD   = 3'd5;

    typedef struct packed {
        logic        we;
        t_addr       waddr;
        logic [7:0]  wdata;
        logic        re;
        t_addr       raddr;
    } t_ram_req;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [7:0]  checksum;
        logic [15:0] oldest_address;
        logic [7:0]  oldest_length;
        logic        rd_ok;
        logic        rd_hdr;
        logic        is_full;
        logic        is_empty;
    } t_fin;

    function automatic t_addr ram_addr(input t_slot slot, input logic [POS_W-1:0] pos);
        logic [ADDR_W+POS_W:0] sum;
        sum = (ADDR_W + POS_W + 1)'(slot) * (ADDR_W + POS_W + 1)'(MAX_PAYLOAD)
            + (ADDR_W + POS_W + 1)'(pos);
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        return (s == t_slot'(QUEUE_DEPTH - 1)) ? '0 : t_slot'(s + 1'b1);
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        return (s == '0) ? t_slot'(QUEUE_DEPTH - 1) : t_slot'(s - 1'b1);
    endfunction

endpackage

/* rtl/prq_if.sv */
// Valid/ready channel interfaces for the packet ring queue: action items in,
// result items out. No dependencies.
`timescale 1ns / 1ps

interface prq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [15:0] dest_address;
    logic [7:0] payload_length;
    logic [7:0] checksum_seed;
    logic [7:0] data_byte;
    logic [7:0] byte_index;

    modport source (output valid, action, dest_address, payload_length, checksum_seed,
                    data_byte, byte_index, input ready);
    modport sink   (input valid, action, dest_address, payload_length, checksum_seed,
                    data_byte, byte_index, output ready);
endinterface

interface prq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  checksum_out;
    logic [15:0] oldest_address;
    logic [7:0]  oldest_length;
    logic [7:0]  read_value;
    logic        is_full;
    logic        is_empty;

    modport source (output valid, status, checksum_out, oldest_address, oldest_length,
                    read_value, is_full, is_empty, input ready);
    modport sink   (input valid, status, checksum_out, oldest_address, oldest_length,
                    read_value, is_full, is_empty, output ready);
endinterface

/* rtl/prq_byte_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module prq_byte_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/prq_ctrl.sv */
// Queue controller: head/tail pointers, slot metadata, open-add tracking and
// checksum; issues payload RAM accesses. Depends on prq_pkg and prq_if.
`timescale 1ns / 1ps

module prq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prq_in_if.sink         i_in,
    output prq_pkg::t_ram_req o_ram,
    output prq_pkg::t_fin  o_fin,
    input  logic           i_fin_take
);
    import prq_pkg::*;

    typedef enum logic {S_IDLE, S_FINISH} t_state;

    t_state      r_state, n_state;
    logic [15:0] r_slot_address [QUEUE_DEPTH];
    logic [7:0]  r_slot_length  [QUEUE_DEPTH];
    t_slot       r_write_slot, n_write_slot;
    t_slot       r_read_slot, n_read_slot;
    logic        r_full, n_full;
    logic        r_add_open, n_add_open;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_byte_position, n_byte_position;
    logic [7:0]  r_checksum, n_checksum;
    logic [2:0]  r_status, n_status;
    logic        r_rd_ok, n_rd_ok;
    logic        r_rd_hdr, n_rd_hdr;

    logic        meta_we;
    t_slot       meta_wa;
    logic [15:0] meta_addr_d;
    logic [7:0]  meta_len_d;
    logic        accept;
    logic        empty;
    logic [7:0]  bl_dec;
    logic [8:0]  idx_limit;
    logic [7:0]  pay_off;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign empty      = !r_full && (r_write_slot == r_read_slot);
    assign bl_dec     = (r_bytes_left != 8'd0) ? r_bytes_left - 8'd1 : 8'd0;
    assign idx_limit  = 9'(HEADER_BYTES) + {1'b0, r_slot_length[r_read_slot]};
    assign pay_off    = i_in.byte_index - 8'(HEADER_BYTES);

    always_comb begin
        n_state         = r_state;
        n_write_slot    = r_write_slot;
        n_read_slot     = r_read_slot;
        n_full          = r_full;
        n_add_open      = r_add_open;
        n_bytes_left    = r_bytes_left;
        n_byte_position = r_byte_position;
        n_checksum      = r_checksum;
        n_status        = r_status;
        n_rd_ok         = r_rd_ok;
        n_rd_hdr        = r_rd_hdr;
        meta_we         = 1'b0;
        meta_wa         = r_write_slot;
        meta_addr_d     = '0;
        meta_len_d      = '0;
        o_ram           = '0;
        o_ram.waddr     = ram_addr(r_write_slot, r_byte_position[POS_W-1:0]);
        o_ram.wdata     = i_in.data_byte;
        o_ram.raddr     = ram_addr(r_read_slot, pay_off[POS_W-1:0]);

        if (r_state == S_FINISH) begin
            if (i_fin_take) begin
                n_state = S_IDLE;
            end
        end else if (accept) begin
            n_state  = S_FINISH;
            n_status = ST_OK;
            n_rd_ok  = 1'b0;
            n_rd_hdr = 1'b0;
            case (i_in.action)
                ACT_BEGIN_ADD: begin
                    if (r_add_open) begin
                        n_status = ST_ADD_OPEN;
                    end else if (r_full) begin
                        n_status = ST_FULL;
                    end else if (i_in.payload_length > 8'(MAX_PAYLOAD)) begin
                        n_status = ST_BAD_LEN;
                    end else begin
                        meta_we         = 1'b1;
                        meta_addr_d     = i_in.dest_address;
                        meta_len_d      = i_in.payload_length;
                        n_checksum      = i_in.checksum_seed;
                        n_byte_position = '0;
                        if (i_in.payload_length == 8'd0) begin
                            n_write_slot = slot_inc(r_write_slot);
                            n_full       = (slot_inc(r_write_slot) == r_read_slot);
                            n_add_open   = 1'b0;
                            n_bytes_left = '0;
                        end else begin
                            n_add_open   = 1'b1;
                            n_bytes_left = i_in.payload_length;
                        end
                    end
                end
                ACT_PAYLOAD_BYTE: begin
                    if (!r_add_open) begin
                        n_status = ST_NO_ADD;
                    end else begin
                        o_ram.we        = (r_byte_position < 8'(MAX_PAYLOAD));
                        n_checksum      = r_checksum + i_in.data_byte;
                        n_byte_position = r_byte_position + 8'd1;
                        n_bytes_left    = bl_dec;
                        if (bl_dec == 8'd0) begin
                            n_write_slot    = slot_inc(r_write_slot);
                            n_full          = (slot_inc(r_write_slot) == r_read_slot);
                            n_add_open      = 1'b0;
                            n_byte_position = '0;
                        end
                    end
                end
                ACT_REMOVE_OLDEST: begin
                    if (r_add_open) begin
                        n_status = ST_ADD_OPEN;
                    end else if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_read_slot = slot_inc(r_read_slot);
                        n_full      = 1'b0;
                    end
                end
                ACT_REMOVE_NEWEST: begin
                    if (r_add_open) begin
                        n_status = ST_ADD_OPEN;
                    end else if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        meta_we      = 1'b1;
                        meta_wa      = slot_dec(r_write_slot);
                        n_write_slot = slot_dec(r_write_slot);
                        n_full       = 1'b0;
                    end
                end
                ACT_READ_OLDEST: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else if ({1'b0, i_in.byte_index} >= idx_limit ||
                                 i_in.byte_index >= 8'(SLOT_STRIDE)) begin
                        n_status = ST_BAD_LEN;
                    end else if ({1'b0, i_in.byte_index} < 9'(HEADER_BYTES)) begin
                        n_rd_ok  = 1'b1;
                        n_rd_hdr = 1'b1;
                    end else begin
                        n_rd_ok  = 1'b1;
                        o_ram.re = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_BAD_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_write_slot    <= '0;
            r_read_slot     <= '0;
            r_full          <= 1'b0;
            r_add_open      <= 1'b0;
            r_bytes_left    <= '0;
            r_byte_position <= '0;
            r_checksum      <= '0;
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                r_slot_address[k] <= '0;
                r_slot_length[k]  <= '0;
            end
        end else begin
            r_state         <= n_state;
            r_write_slot    <= n_write_slot;
            r_read_slot     <= n_read_slot;
            r_full          <= n_full;
            r_add_open      <= n_add_open;
            r_bytes_left    <= n_bytes_left;
            r_byte_position <= n_byte_position;
            r_checksum      <= n_checksum;
            if (meta_we) begin
                r_slot_address[meta_wa] <= meta_addr_d;
                r_slot_length[meta_wa]  <= meta_len_d;
            end
        end
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
        r_rd_hdr <= n_rd_hdr;
    end

    always_comb begin
        o_fin                = '0;
        o_fin.valid          = (r_state == S_FINISH);
        o_fin.status         = r_status;
        o_fin.checksum       = r_checksum;
        o_fin.oldest_address = empty ? 16'd0 : r_slot_address[r_read_slot];
        o_fin.oldest_length  = empty ? 8'd0 : r_slot_length[r_read_slot];
        o_fin.rd_ok          = r_rd_ok;
        o_fin.rd_hdr         = r_rd_hdr;
        o_fin.is_full        = r_full;
        o_fin.is_empty       = empty;
    end

`ifndef SYNTHESIS
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_write_slot == r_read_slot))
        else $error("full flag set with head and tail apart");
    a_open_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_add_open |-> (r_bytes_left != 8'd0))
        else $error("add open with no bytes left");
    a_closed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_add_open |-> (r_bytes_left == 8'd0 && r_byte_position == 8'd0))
        else $error("byte counters not cleared after commit");
    a_accept_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_fin.valid)
        else $error("accepted transfer produced no result");
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram.we && o_ram.re))
        else $error("payload RAM read and write in one cycle");
`endif

endmodule

/* rtl/packet_ring_queue_top.sv */
// Top level of the packet ring queue: controller, payload byte RAM and the
// output result register. Depends on prq_pkg, prq_if, prq_ctrl, prq_byte_ram.
//
// Usage: actions enter on i_in (begin_add, payload_byte, remove_oldest,
// remove_newest, read_oldest_byte); one result per action leaves on o_out,
// carrying status, running checksum, the oldest entry's address and length,
// the byte read and the full/empty flags after the action.
// Each action is performed in controller state S_IDLE with at most one payload
// RAM access; in state S_FINISH the result is formed from the RAM's registered
// read port and loaded into the output register once that register is free.
// No new action is taken until the previous result has been loaded.
// Header bytes always read as zero and are not stored in the RAM.
// Reset (synchronous, active low) empties the queue, closes any open add and
// clears the checksum and slot metadata; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register; one more
// action is taken and completed internally, then i_in.ready stays low until
// the output register is free.
`timescale 1ns / 1ps

module packet_ring_queue_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_in_if.sink    i_in,
    prq_out_if.source o_out
);
    import prq_pkg::*;

    t_ram_req    ram_req;
    t_fin        fin;
    logic        fin_take;
    logic [7:0]  ram_q;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [7:0]  r_checksum;
    logic [15:0] r_oldest_address;
    logic [7:0]  r_oldest_length;
    logic [7:0]  r_read_value;
    logic        r_is_full;
    logic        r_is_empty;

    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_ram      (ram_req),
        .o_fin      (fin),
        .i_fin_take (fin_take)
    );

    prq_byte_ram #(
        .DATA_W (8),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_q)
    );

    assign fin_take = fin.valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fin_take) begin
            r_status         <= fin.status;
            r_checksum       <= fin.checksum;
            r_oldest_address <= fin.oldest_address;
            r_oldest_length  <= fin.oldest_length;
            r_read_value     <= (fin.rd_ok && !fin.rd_hdr) ? ram_q : 8'd0;
            r_is_full        <= fin.is_full;
            r_is_empty       <= fin.is_empty;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.checksum_out   = r_checksum;
    assign o_out.oldest_address = r_oldest_address;
    assign o_out.oldest_length  = r_oldest_length;
    assign o_out.read_value     = r_read_value;
    assign o_out.is_full        = r_is_full;
    assign o_out.is_empty       = r_is_empty;

endmodule

/* tb/packet_ring_queue_top_tb.sv */
// Testbench for packet_ring_queue_top: directed and random actions on the input
// channel, results checked field by field against a built-in queue predictor.
// Depends on prq_pkg, prq_if and the packet ring queue RTL.
`timescale 1ns / 1ps

module packet_ring_queue_top_tb;
    import prq_pkg::*;

    localparam int         IDLE_LIMIT   = 1000;
    localparam int         RANDOM_ITEMS = 850;
    localparam logic [2:0] ACT_LAST     = 3'd7;

    typedef struct {
        logic [2:0]  action;
        logic [15:0] dest_address;
        logic [7:0]  payload_length;
        logic [7:0]  checksum_seed;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
    } t_action;

    typedef struct {
        logic [2:0]  status;
        logic [7:0]  checksum_out;
        logic [15:0] oldest_address;
        logic [7:0]  oldest_length;
        logic [7:0]  read_value;
        logic        is_full;
        logic        is_empty;
    } t_result;

    class prq_scoreboard;
        logic [15:0] entry_addr [QUEUE_DEPTH];
        logic [7:0]  entry_len [QUEUE_DEPTH];
        logic [7:0]  entry_bytes [QUEUE_DEPTH][SLOT_STRIDE];
        int unsigned head;
        int unsigned tail;
        int unsigned bytes_left;
        int unsigned byte_pos;
        bit          full;
        bit          open;
        logic [7:0]  csum;
        t_result     expected_q[$];
        int          errors;

        function new();
            foreach (entry_addr[i]) begin
                entry_addr[i] = '0;
                entry_len[i]  = '0;
            end
            foreach (entry_bytes[i, j]) entry_bytes[i][j] = '0;
            head       = 0;
            tail       = 0;
            bytes_left = 0;
            byte_pos   = 0;
            full       = 0;
            open       = 0;
            csum       = '0;
            errors     = 0;
        endfunction

        function bit empty();
            return !full && head == tail;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] oldest_len();
            return empty() ? 8'd0 : entry_len[tail];
        endfunction

        function void close_entry();
            head = (head + 1) % QUEUE_DEPTH;
            if (head == tail) full = 1;
            open       = 0;
            bytes_left = 0;
            byte_pos   = 0;
        endfunction

        function void note_action(t_action a);
            t_result    r;
            logic [2:0] st;
            logic [7:0] value;
            st    = ST_OK;
            value = '0;
            case (a.action)
                ACT_BEGIN_ADD: begin
                    if (open) st = ST_ADD_OPEN;
                    else if (full) st = ST_FULL;
                    else if (a.payload_length > MAX_PAYLOAD) st = ST_BAD_LEN;
                    else begin
                        entry_addr[head] = a.dest_address;
                        entry_len[head]  = a.payload_length;
                        for (int i = 0; i < HEADER_BYTES; i++) entry_bytes[head][i] = '0;
                        csum       = a.checksum_seed;
                        open       = 1;
                        bytes_left = a.payload_length;
                        byte_pos   = 0;
                        if (a.payload_length == 0) close_entry();
                    end
                end
                ACT_PAYLOAD_BYTE: begin
                    if (!open) st = ST_NO_ADD;
                    else begin
                        if (byte_pos < MAX_PAYLOAD)
                            entry_bytes[head][HEADER_BYTES + byte_pos] = a.data_byte;
                        csum = csum + a.data_byte;
                        byte_pos++;
                        if (bytes_left > 0) bytes_left--;
                        if (bytes_left == 0) close_entry();
                    end
                end
                ACT_REMOVE_OLDEST: begin
                    if (open) st = ST_ADD_OPEN;
                    else if (empty()) st = ST_EMPTY;
                    else begin
                        tail = (tail + 1) % QUEUE_DEPTH;
                        full = 0;
                    end
                end
                ACT_REMOVE_NEWEST: begin
                    if (open) st = ST_ADD_OPEN;
                    else if (empty()) st = ST_EMPTY;
                    else begin
                        head = (head == 0) ? QUEUE_DEPTH - 1 : head - 1;
                        entry_addr[head] = '0;
                        entry_len[head]  = '0;
                        full = 0;
                    end
                end
                ACT_READ_OLDEST: begin
                    if (empty()) st = ST_EMPTY;
                    else if (int'(a.byte_index) >= HEADER_BYTES + int'(entry_len[tail]) ||
                             int'(a.byte_index) >= SLOT_STRIDE) st = ST_BAD_LEN;
                    else value = entry_bytes[tail][a.byte_index];
                end
                default: st = ST_BAD_LEN;
            endcase
            r.status         = st;
            r.checksum_out   = csum;
            r.oldest_address = empty() ? 16'd0 : entry_addr[tail];
            r.oldest_length  = empty() ? 8'd0 : entry_len[tail];
            r.read_value     = value;
            r.is_full        = full;
            r.is_empty       = empty();
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got status %0h",
                         $time, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("checksum_out", want.checksum_out, got.checksum_out);
            compare_field("oldest_address", want.oldest_address, got.oldest_address);
            compare_field("oldest_length", want.oldest_length, got.oldest_length);
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("is_empty", want.is_empty, got.is_empty);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    prq_in_if  in_ch ();
    prq_out_if out_ch ();

    packet_ring_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    prq_scoreboard sb;
    int            sent;
    int            idle_cycles;
    int            stall_left;
    int            calm_out;
    int            calm_in;

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[packet_ring_queue_top] ERROR");
        $finish;
    end

    // receiver: short stalls, a few long ones, and calm stretches
    initial begin
        int r;
        out_ch.ready <= 1'b0;
        stall_left = 0;
        calm_out   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (calm_out > 0) calm_out--;
                else if (r < 20) stall_left = $urandom_range(1, 3);
                else if (r < 23) stall_left = $urandom_range(10, 40);
                else if (r < 26) calm_out = $urandom_range(40, 150);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status         = out_ch.status;
            got.checksum_out   = out_ch.checksum_out;
            got.oldest_address = out_ch.oldest_address;
            got.oldest_length  = out_ch.oldest_length;
            got.read_value     = out_ch.read_value;
            got.is_full        = out_ch.is_full;
            got.is_empty       = out_ch.is_empty;
            sb.check_result(got);
        end
    end

    function automatic t_action rand_action(logic [2:0] act);
        t_action a;
        a.action         = act;
        a.dest_address   = 16'($urandom);
        a.payload_length = 8'($urandom);
        a.checksum_seed  = 8'($urandom);
        a.data_byte      = 8'($urandom);
        a.byte_index     = 8'($urandom);
        return a;
    endfunction

    function automatic t_action add_action(int len, logic [15:0] addr, logic [7:0] seed);
        t_action a;
        a                = rand_action(ACT_BEGIN_ADD);
        a.payload_length = 8'(len);
        a.dest_address   = addr;
        a.checksum_seed  = seed;
        return a;
    endfunction

    function automatic t_action byte_action(logic [7:0] data);
        t_action a;
        a           = rand_action(ACT_PAYLOAD_BYTE);
        a.data_byte = data;
        return a;
    endfunction

    function automatic t_action read_action(int idx);
        t_action a;
        a            = rand_action(ACT_READ_OLDEST);
        a.byte_index = 8'(idx);
        return a;
    endfunction

    // hold valid until the transfer, then record it
    task automatic send(t_action a);
        in_ch.valid          <= 1'b1;
        in_ch.action         <= a.action;
        in_ch.dest_address   <= a.dest_address;
        in_ch.payload_length <= a.payload_length;
        in_ch.checksum_seed  <= a.checksum_seed;
        in_ch.data_byte      <= a.data_byte;
        in_ch.byte_index     <= a.byte_index;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_action(a);
        sent++;
    endtask

    task automatic pace();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (calm_in > 0) begin
            calm_in--;
            n = 0;
        end else if (r < 55) n = 0;
        else if (r < 88) n = $urandom_range(1, 3);
        else if (r < 96) n = $urandom_range(4, 10);
        else if (r < 98) n = $urandom_range(15, 40);
        else begin
            calm_in = $urandom_range(40, 120);
            n = 0;
        end
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic step(t_action a);
        send(a);
        pace();
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic random_read();
        int r;
        int len;
        r   = $urandom_range(0, 99);
        len = int'(sb.oldest_len());
        if (!sb.empty() && r < 80) step(read_action($urandom_range(0, HEADER_BYTES + len - 1)));
        else if (r < 90) step(read_action(HEADER_BYTES + len));
        else step(read_action($urandom_range(0, 255)));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 6);
        if (r < 85) return $urandom_range(7, 24);
        if (r < 92) return $urandom_range(25, MAX_PAYLOAD - 1);
        if (r < 96) return MAX_PAYLOAD;
        return $urandom_range(MAX_PAYLOAD + 1, 255);
    endfunction

    // begin_add and its payload, with occasional reads between bytes, cut short when not complete
    task automatic add_packet(int len, bit complete);
        int n;
        step(add_action(len, 16'($urandom), 8'($urandom)));
        if (len > MAX_PAYLOAD || len == 0) n = 0;
        else if (complete) n = len;
        else n = $urandom_range(0, len - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8) random_read();
            step(byte_action(8'($urandom)));
        end
    endtask

    initial begin
        int  r;
        bit  paused;
        sb      = new();
        sent    = 0;
        calm_in = 0;
        paused  = 0;
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACT_BEGIN_ADD;
        in_ch.dest_address   <= '0;
        in_ch.payload_length <= '0;
        in_ch.checksum_seed  <= '0;
        in_ch.data_byte      <= '0;
        in_ch.byte_index     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        step(rand_action(ACT_REMOVE_OLDEST));
        step(rand_action(ACT_REMOVE_NEWEST));
        step(read_action(0));
        step(byte_action(8'hA5));
        for (int a = int'(ACT_READ_OLDEST) + 1; a <= int'(ACT_LAST); a++) step(rand_action(3'(a)));
        step(add_action(MAX_PAYLOAD + 1, 16'h1234, 8'h11));
        step(add_action(255, 16'h4321, 8'h22));
        step(add_action(0, 16'hFFFF, 8'hFF));
        step(read_action(HEADER_BYTES - 1));
        step(read_action(HEADER_BYTES));
        step(add_action(2, 16'h0000, 8'h80));
        step(add_action(1, 16'h5555, 8'h33));
        step(rand_action(ACT_REMOVE_OLDEST));
        step(rand_action(ACT_REMOVE_NEWEST));
        step(read_action(0));
        step(byte_action(8'hFF));
        step(byte_action(8'h81));
        step(rand_action(ACT_REMOVE_NEWEST));
        step(rand_action(ACT_REMOVE_OLDEST));
        step(add_action(MAX_PAYLOAD, 16'hA5A5, 8'h00));
        drain_results();

        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) add_packet(pick_length(), 1'b1);
            else if (r < 50) add_packet($urandom_range(1, 20), 1'b0);
            else if (r < 64) step(rand_action(ACT_REMOVE_OLDEST));
            else if (r < 72) step(rand_action(ACT_REMOVE_NEWEST));
            else if (r < 86) repeat ($urandom_range(1, 3)) random_read();
            else if (r < 97) step(rand_action(3'($urandom_range(0, int'(ACT_LAST)))));
            else while (!sb.empty() && !sb.open) step(rand_action(ACT_REMOVE_OLDEST));
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) $display("[packet_ring_queue_top] OK");
        else $display("[packet_ring_queue_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/prq_pkg.sv
rtl/prq_if.sv
rtl/prq_byte_ram.sv
rtl/prq_ctrl.sv
rtl/packet_ring_queue_top.sv
tb/packet_ring_queue_top_tb.sv
